### rtl/core/qau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qau_pkg
// Shared widths, command codes, beat types and clip helpers for the
// fixed-point quaternion unit.
// ----------------------------------------------------------------------------
package qau_pkg;

	localparam int CW    = 16;          // component width
	localparam int FB    = 14;          // fraction bits
	localparam int EPS_W = 15;          // tolerance register width
	localparam int PW    = 2 * CW;      // single product
	localparam int SW    = 2 * CW + 2;  // sum of up to four products
	localparam int MW    = SW + CW;     // sum times component
	localparam int WW    = 3 * CW + 4;  // rotate accumulator

	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(16);

	typedef enum logic [3:0] {
		CMD_ADD     = 4'd0,
		CMD_SUB     = 4'd1,
		CMD_NEGATE  = 4'd2,
		CMD_CONJ    = 4'd3,
		CMD_SCALE   = 4'd4,
		CMD_PRODUCT = 4'd5,
		CMD_ROTATE  = 4'd6,
		CMD_DOT     = 4'd7,
		CMD_EQUAL   = 4'd8,
		CMD_ORIENT  = 4'd9
	} qau_cmd_t;

	// how the final stage builds the result
	typedef enum logic [1:0] {
		CLS_DIRECT,
		CLS_LIN,
		CLS_ROT
	} qau_cls_t;

	typedef logic signed [CW-1:0] comp_t;

	typedef struct packed {
		logic [3:0] command;
		comp_t      a_x;
		comp_t      a_y;
		comp_t      a_z;
		comp_t      a_w;
		comp_t      b_x;
		comp_t      b_y;
		comp_t      b_z;
		comp_t      b_w;
	} qau_req_t;

	typedef struct packed {
		comp_t r_x;
		comp_t r_y;
		comp_t r_z;
		comp_t r_w;
		logic  match;
		logic  saturated;
	} qau_res_t;

	// result of the commands that finish in the first stage
	typedef struct packed {
		comp_t [3:0] r;
		logic        match;
		logic        sat;
	} qau_direct_t;

	typedef struct packed {
		logic  sat;
		comp_t v;
	} clip_t;

	localparam comp_t CMAX = comp_t'({1'b0, {(CW-1){1'b1}}});
	localparam comp_t CMIN = comp_t'({1'b1, {(CW-1){1'b0}}});

	function automatic clip_t clip_narrow(input logic signed [CW:0] v);
		clip_t c;
		c.sat = (v[CW] != v[CW-1]);
		if (!c.sat) begin
			c.v = v[CW-1:0];
		end else if (v[CW]) begin
			c.v = CMIN;
		end else begin
			c.v = CMAX;
		end
		return c;
	endfunction

	function automatic clip_t clip_wide(input logic signed [WW-1:0] v);
		clip_t c;
		c.sat = !((&v[WW-1:CW-1]) || !(|v[WW-1:CW-1]));
		if (!c.sat) begin
			c.v = v[CW-1:0];
		end else if (v[WW-1]) begin
			c.v = CMIN;
		end else begin
			c.v = CMAX;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### rtl/core/qau_direct.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qau_direct
// Command decode plus the short commands: add, subtract, negate, conjugate
// and the two tolerance compares, finished in one stage.
// ----------------------------------------------------------------------------
module qau_direct import qau_pkg::*; (
	input  qau_req_t          req,
	input  logic [EPS_W-1:0]  eps,
	output qau_direct_t       dir,
	output qau_cls_t          cls
);

	comp_t              a [4];
	comp_t              b [4];
	logic signed [CW:0] sum [4];
	logic signed [CW:0] dif [4];
	logic [CW:0]        mag_s [4];
	logic [CW:0]        mag_d [4];
	logic [3:0]         near_s;
	logic [3:0]         near_d;
	clip_t              c_add [4];
	clip_t              c_sub [4];
	clip_t              c_neg [4];

	always_comb begin
		a[0] = req.a_x; a[1] = req.a_y; a[2] = req.a_z; a[3] = req.a_w;
		b[0] = req.b_x; b[1] = req.b_y; b[2] = req.b_z; b[3] = req.b_w;
		for (int i = 0; i < 4; i++) begin
			sum[i]    = (CW+1)'(a[i]) + (CW+1)'(b[i]);
			dif[i]    = (CW+1)'(a[i]) - (CW+1)'(b[i]);
			c_add[i]  = clip_narrow(sum[i]);
			c_sub[i]  = clip_narrow(dif[i]);
			c_neg[i]  = clip_narrow(-((CW+1)'(a[i])));
			mag_s[i]  = sum[i][CW] ? (CW+1)'(-sum[i]) : (CW+1)'(sum[i]);
			mag_d[i]  = dif[i][CW] ? (CW+1)'(-dif[i]) : (CW+1)'(dif[i]);
			near_s[i] = (mag_s[i] <= (CW+1)'(eps));
			near_d[i] = (mag_d[i] <= (CW+1)'(eps));
		end
	end

	always_comb begin
		dir = '0;
		cls = CLS_DIRECT;
		unique case (req.command)
			CMD_ADD: begin
				for (int i = 0; i < 4; i++) begin
					dir.r[i] = c_add[i].v;
					dir.sat  = dir.sat | c_add[i].sat;
				end
			end
			CMD_SUB: begin
				for (int i = 0; i < 4; i++) begin
					dir.r[i] = c_sub[i].v;
					dir.sat  = dir.sat | c_sub[i].sat;
				end
			end
			CMD_NEGATE: begin
				for (int i = 0; i < 4; i++) begin
					dir.r[i] = c_neg[i].v;
					dir.sat  = dir.sat | c_neg[i].sat;
				end
			end
			CMD_CONJ: begin
				for (int i = 0; i < 3; i++) begin
					dir.r[i] = c_neg[i].v;
					dir.sat  = dir.sat | c_neg[i].sat;
				end
				dir.r[3] = a[3];
			end
			CMD_SCALE, CMD_PRODUCT, CMD_DOT: cls = CLS_LIN;
			CMD_ROTATE: cls = CLS_ROT;
			CMD_EQUAL:  dir.match = &near_d;
			CMD_ORIENT: dir.match = (&near_d) || (&near_s);
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/quaternion_arithmetic_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Q2.14 quaternion add/sub/negate/conjugate/scale/product/rotate/dot and
// tolerance compares, five register stages.
// ----------------------------------------------------------------------------
// One beat in, one beat out, one beat per cycle sustained while res_stall
// is low. Each command passes the five register stages in order: stage 1
// forms all sixteen a*b products and four squares, stage 2 the sums, stage 3
// the second rotate multiplies, stage 4 the final rotate sum and rounding
// bias, stage 5 the shift and clip into the output register. Stall ripples
// back stage by stage and empty stages fill while the output is held, so up
// to five beats can be in flight. Products are rounded to nearest (ties
// toward plus infinity) and clipped; saturated flags any clipped component.
// The tolerance register may be written only while no beat is in flight.
module quaternion_arithmetic_unit import qau_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  qau_req_t         cmd_data,
	output logic             res_valid,
	input  logic             res_stall,
	output qau_res_t         res_data,
	input  logic             eps_we,
	input  logic [EPS_W-1:0] eps_wdata
);

	localparam logic signed [WW-1:0] HALF_LIN =
		{{(WW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
	localparam logic signed [WW-1:0] HALF_ROT =
		{{(WW-2*FB){1'b0}}, 1'b1, {(2*FB-1){1'b0}}};

	logic [EPS_W-1:0] eps_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;

	assign adv_s5    = !v_s5 || !res_stall;
	assign adv_s4    = !v_s4 || adv_s5;
	assign adv_s3    = !v_s3 || adv_s4;
	assign adv_s2    = !v_s2 || adv_s3;
	assign adv_s1    = !v_s1 || adv_s2;
	assign cmd_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
		end else begin
			if (eps_we) eps_q <= eps_wdata;
			if (adv_s1) v_s1 <= cmd_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	// ---------------- stage 1: decode, short commands, products
	comp_t       a_in [4];
	comp_t       b_in [4];
	qau_direct_t dir_in;
	qau_cls_t    cls_in;

	qau_direct u_direct (
		.req (cmd_data),
		.eps (eps_q),
		.dir (dir_in),
		.cls (cls_in)
	);

	always_comb begin
		a_in[0] = cmd_data.a_x; a_in[1] = cmd_data.a_y;
		a_in[2] = cmd_data.a_z; a_in[3] = cmd_data.a_w;
		b_in[0] = cmd_data.b_x; b_in[1] = cmd_data.b_y;
		b_in[2] = cmd_data.b_z; b_in[3] = cmd_data.b_w;
	end

	logic signed [PW-1:0] p_s1 [4][4];   // p_s1[i][j] = a_i * b_j
	logic signed [PW-1:0] sq_s1 [4];
	comp_t                a_s1 [4];
	comp_t                b_s1 [3];
	logic [3:0]           cmd_s1;
	qau_cls_t             cls_s1;
	qau_direct_t          dir_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					p_s1[i][j] <= PW'(a_in[i]) * PW'(b_in[j]);
				end
				sq_s1[i] <= PW'(a_in[i]) * PW'(a_in[i]);
				a_s1[i]  <= a_in[i];
			end
			for (int i = 0; i < 3; i++) b_s1[i] <= b_in[i];
			cmd_s1 <= cmd_data.command;
			cls_s1 <= cls_in;
			dir_s1 <= dir_in;
		end
	end

	// ---------------- stage 2: sums of products
	logic signed [SW-1:0] lin_d [4];

	always_comb begin
		for (int i = 0; i < 4; i++) lin_d[i] = '0;
		unique case (cmd_s1)
			CMD_SCALE: begin
				for (int i = 0; i < 4; i++) lin_d[i] = SW'(p_s1[i][3]);
			end
			CMD_PRODUCT: begin
				// Hamilton product B*A
				lin_d[0] = SW'(p_s1[3][0]) + SW'(p_s1[2][1])
				         - SW'(p_s1[1][2]) + SW'(p_s1[0][3]);
				lin_d[1] = SW'(p_s1[3][1]) + SW'(p_s1[0][2])
				         + SW'(p_s1[1][3]) - SW'(p_s1[2][0]);
				lin_d[2] = SW'(p_s1[1][0]) - SW'(p_s1[0][1])
				         + SW'(p_s1[3][2]) + SW'(p_s1[2][3]);
				lin_d[3] = SW'(p_s1[3][3]) - SW'(p_s1[0][0])
				         - SW'(p_s1[1][1]) - SW'(p_s1[2][2]);
			end
			CMD_DOT: begin
				lin_d[3] = SW'(p_s1[0][0]) + SW'(p_s1[1][1])
				         + SW'(p_s1[2][2]) + SW'(p_s1[3][3]);
			end
			default: ;
		endcase
	end

	logic signed [SW-1:0] lin_s2 [4];
	logic signed [SW-1:0] d_s2;         // u.v
	logic signed [SW-1:0] k_s2;         // s*s - u.u
	logic signed [SW-1:0] c_s2 [3];     // u x v
	comp_t                a_s2 [4];
	comp_t                b_s2 [3];
	qau_cls_t             cls_s2;
	qau_direct_t          dir_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int i = 0; i < 4; i++) begin
				lin_s2[i] <= lin_d[i];
				a_s2[i]   <= a_s1[i];
			end
			for (int i = 0; i < 3; i++) b_s2[i] <= b_s1[i];
			d_s2    <= SW'(p_s1[0][0]) + SW'(p_s1[1][1]) + SW'(p_s1[2][2]);
			k_s2    <= SW'(sq_s1[3]) - SW'(sq_s1[0]) - SW'(sq_s1[1]) - SW'(sq_s1[2]);
			c_s2[0] <= SW'(p_s1[1][2]) - SW'(p_s1[2][1]);
			c_s2[1] <= SW'(p_s1[2][0]) - SW'(p_s1[0][2]);
			c_s2[2] <= SW'(p_s1[0][1]) - SW'(p_s1[1][0]);
			cls_s2  <= cls_s1;
			dir_s2  <= dir_s1;
		end
	end

	// ---------------- stage 3: rotate terms
	logic signed [MW-1:0] t1_s3 [3];    // (u.v) u_i
	logic signed [MW-1:0] t2_s3 [3];    // (s*s - u.u) v_i
	logic signed [MW-1:0] t3_s3 [3];    // s (u x v)_i
	logic signed [SW-1:0] lin_s3 [4];
	qau_cls_t             cls_s3;
	qau_direct_t          dir_s3;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			for (int i = 0; i < 3; i++) begin
				t1_s3[i] <= MW'(d_s2) * MW'(a_s2[i]);
				t2_s3[i] <= MW'(k_s2) * MW'(b_s2[i]);
				t3_s3[i] <= MW'(c_s2[i]) * MW'(a_s2[3]);
			end
			for (int i = 0; i < 4; i++) lin_s3[i] <= lin_s2[i];
			cls_s3 <= cls_s2;
			dir_s3 <= dir_s2;
		end
	end

	// ---------------- stage 4: final sum plus rounding bias
	logic signed [WW-1:0] w_d [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (cls_s3 == CLS_ROT) begin
				if (i < 3) begin
					w_d[i] = (WW'(t1_s3[i]) <<< 1) + WW'(t2_s3[i])
					       + (WW'(t3_s3[i]) <<< 1) + HALF_ROT;
				end else begin
					w_d[i] = '0;
				end
			end else begin
				w_d[i] = WW'(lin_s3[i]) + HALF_LIN;
			end
		end
	end

	logic signed [WW-1:0] w_s4 [4];
	qau_cls_t             cls_s4;
	qau_direct_t          dir_s4;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			for (int i = 0; i < 4; i++) w_s4[i] <= w_d[i];
			cls_s4 <= cls_s3;
			dir_s4 <= dir_s3;
		end
	end

	// ---------------- stage 5: shift, clip, output register
	clip_t    cl [4];
	qau_res_t res_d;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (cls_s4 == CLS_ROT) begin
				cl[i] = clip_wide(w_s4[i] >>> (2 * FB));
			end else begin
				cl[i] = clip_wide(w_s4[i] >>> FB);
			end
		end
		if (cls_s4 == CLS_DIRECT) begin
			res_d.r_x       = dir_s4.r[0];
			res_d.r_y       = dir_s4.r[1];
			res_d.r_z       = dir_s4.r[2];
			res_d.r_w       = dir_s4.r[3];
			res_d.match     = dir_s4.match;
			res_d.saturated = dir_s4.sat;
		end else begin
			res_d.r_x       = cl[0].v;
			res_d.r_y       = cl[1].v;
			res_d.r_z       = cl[2].v;
			res_d.r_w       = cl[3].v;
			res_d.match     = 1'b0;
			res_d.saturated = cl[0].sat | cl[1].sat | cl[2].sat | cl[3].sat;
		end
	end

	qau_res_t res_s5;

	always_ff @(posedge clk) begin
		if (adv_s5) res_s5 <= res_d;
	end

	assign res_valid = v_s5;
	assign res_data  = res_s5;

	// ---------------- checks
	a_match_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.match) |->
			(!res_data.saturated && res_data.r_x == '0 && res_data.r_y == '0 &&
			 res_data.r_z == '0 && res_data.r_w == '0))
		else $error("compare beat carries nonzero components or saturation");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> v_s1)
		else $error("accepted beat missing from stage 1");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && adv_s5) |=> res_valid)
		else $error("beat lost between stage 4 and output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !adv_s5) |=> (v_s4 && $stable(cls_s4)))
		else $error("stage 4 changed while output held");

endmodule
`default_nettype wire

### sim/qau_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_result_checker
// Watches the command and result channels of the quaternion unit, predicts
// each result beat from the accepted command beat and the current tolerance,
// and compares every result field in order of arrival.
// ----------------------------------------------------------------------------
module qau_result_checker import qau_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  logic             cmd_stall,
	input  qau_req_t         cmd_data,
	input  logic             res_valid,
	input  logic             res_stall,
	input  qau_res_t         res_data,
	input  logic             eps_we,
	input  logic [EPS_W-1:0] eps_wdata,
	output int               fail_count,
	output int               pending,
	output int               checked
);

	logic [EPS_W-1:0] tolerance;
	qau_res_t         awaited_results[$];
	qau_res_t         want_res;
	int               bad_total  = 0;
	int               seen_total = 0;

	// round half up at bit sh, then clip to the component range
	function automatic clip_t round_clip(input longint v, input int sh);
		longint t;
		clip_t  c;
		t = v;
		if (sh > 0) begin
			t = (t + (longint'(1) <<< (sh - 1))) >>> sh;
		end
		c.sat = 1'b0;
		if (t > longint'(CMAX)) begin
			c.sat = 1'b1;
			c.v   = CMAX;
		end else if (t < longint'(CMIN)) begin
			c.sat = 1'b1;
			c.v   = CMIN;
		end else begin
			c.v = comp_t'(t);
		end
		return c;
	endfunction

	function automatic qau_res_t predict_qau_result(input qau_req_t q,
			input logic [EPS_W-1:0] tol);
		longint   a[4];
		longint   b[4];
		longint   acc[4];
		longint   d;
		int       sh;
		int       i;
		int       j;
		int       p;
		int       k;
		bit       sat;
		bit       hit;
		bit       hit_neg;
		clip_t    c;
		qau_res_t res;
		a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z; a[3] = q.a_w;
		b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z; b[3] = q.b_w;
		for (i = 0; i < 4; i++) begin
			acc[i] = 0;
		end
		sh  = 0;
		sat = 1'b0;
		res = '0;

		hit     = 1'b1;
		hit_neg = 1'b1;
		for (i = 0; i < 4; i++) begin
			d = a[i] - b[i];
			if (d < 0) d = -d;
			if (d > longint'(tol)) hit = 1'b0;
			d = a[i] + b[i];
			if (d < 0) d = -d;
			if (d > longint'(tol)) hit_neg = 1'b0;
		end

		case (q.command)
			CMD_ADD: begin
				for (i = 0; i < 4; i++) acc[i] = a[i] + b[i];
			end
			CMD_SUB: begin
				for (i = 0; i < 4; i++) acc[i] = a[i] - b[i];
			end
			CMD_NEGATE: begin
				for (i = 0; i < 4; i++) acc[i] = -a[i];
			end
			CMD_CONJ: begin
				for (i = 0; i < 3; i++) acc[i] = -a[i];
				acc[3] = a[3];
			end
			CMD_SCALE: begin
				for (i = 0; i < 4; i++) acc[i] = a[i] * b[3];
				sh = FB;
			end
			CMD_PRODUCT: begin
				// B*A: operand B on the left
				acc[0] = b[0]*a[3] + b[1]*a[2] - b[2]*a[1] + b[3]*a[0];
				acc[1] = -b[0]*a[2] + b[1]*a[3] + b[2]*a[0] + b[3]*a[1];
				acc[2] = b[0]*a[1] - b[1]*a[0] + b[2]*a[3] + b[3]*a[2];
				acc[3] = -b[0]*a[0] - b[1]*a[1] - b[2]*a[2] + b[3]*a[3];
				sh = FB;
			end
			CMD_ROTATE: begin
				for (i = 0; i < 3; i++) begin
					p = (i + 1) % 3;
					k = (i + 2) % 3;
					for (j = 0; j < 3; j++) begin
						acc[i] += 2 * a[i] * a[j] * b[j] - a[j] * a[j] * b[i];
					end
					acc[i] += a[3] * a[3] * b[i];
					acc[i] += 2 * a[3] * (a[p] * b[k] - a[k] * b[p]);
				end
				sh = 2 * FB;
			end
			CMD_DOT: begin
				for (i = 0; i < 4; i++) acc[3] += a[i] * b[i];
				sh = FB;
			end
			CMD_EQUAL:  res.match = hit;
			CMD_ORIENT: res.match = hit | hit_neg;
			default: ;
		endcase

		c = round_clip(acc[0], sh); res.r_x = c.v; sat |= c.sat;
		c = round_clip(acc[1], sh); res.r_y = c.v; sat |= c.sat;
		c = round_clip(acc[2], sh); res.r_z = c.v; sat |= c.sat;
		c = round_clip(acc[3], sh); res.r_w = c.v; sat |= c.sat;
		res.saturated = sat;
		return res;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			bad_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance <= EPS_RESET;
			awaited_results.delete();
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			if (eps_we) tolerance <= eps_wdata;
			if (res_valid && !res_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result beat arrived with no command outstanding");
					bad_total++;
				end else begin
					want_res = awaited_results.pop_front();
					check_field("r_x", want_res.r_x, res_data.r_x);
					check_field("r_y", want_res.r_y, res_data.r_y);
					check_field("r_z", want_res.r_z, res_data.r_z);
					check_field("r_w", want_res.r_w, res_data.r_w);
					check_field("match", want_res.match, res_data.match);
					check_field("saturated", want_res.saturated, res_data.saturated);
					seen_total++;
				end
			end
			if (cmd_valid && !cmd_stall) begin
				awaited_results.push_back(predict_qau_result(cmd_data, tolerance));
			end
			fail_count <= bad_total;
			pending    <= awaited_results.size();
			checked    <= seen_total;
		end
	end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives command beats into the quaternion unit with random gaps and result
// stalls, walks the tolerance register through several values, and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
module tb import qau_pkg::*; ();

	localparam logic [3:0]       CMD_UNUSED_LO = 4'd10;
	localparam logic [3:0]       CMD_UNUSED_HI = 4'd15;
	localparam logic [EPS_W-1:0] EPS_MAX       = '1;
	localparam comp_t            UNIT          = 16384;
	localparam comp_t            HALF          = 8192;
	localparam comp_t            COS45         = 11585;
	localparam int               PHASE_BEATS   = 110;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             cmd_valid = 1'b0;
	logic             cmd_stall;
	qau_req_t         cmd_data  = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	qau_res_t         res_data;
	logic             eps_we    = 1'b0;
	logic [EPS_W-1:0] eps_wdata = '0;

	int fail_count;
	int pending;
	int checked;
	int beats_sent    = 0;
	int settings_used = 0;
	bit steady        = 1'b0;

	quaternion_arithmetic_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.eps_we    (eps_we),
		.eps_wdata (eps_wdata)
	);

	qau_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_data   (cmd_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data),
		.eps_we     (eps_we),
		.eps_wdata  (eps_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		res_stall <= !steady && ($urandom_range(99) < 31);
	end

	function automatic qau_req_t make_beat(input logic [3:0] cmd,
			input comp_t ax, input comp_t ay, input comp_t az, input comp_t aw,
			input comp_t bx, input comp_t by, input comp_t bz, input comp_t bw);
		qau_req_t q;
		q.command = cmd;
		q.a_x = ax; q.a_y = ay; q.a_z = az; q.a_w = aw;
		q.b_x = bx; q.b_y = by; q.b_z = bz; q.b_w = bw;
		return q;
	endfunction

	function automatic comp_t rand_comp();
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0, 1, 2, 3: return comp_t'($urandom);
			4, 5:       return comp_t'(int'($urandom_range(2 * UNIT)) - UNIT);
			6: begin
				case ($urandom_range(4))
					0:       return CMAX;
					1:       return CMIN;
					2:       return comp_t'(1);
					3:       return comp_t'(-1);
					default: return comp_t'(0);
				endcase
			end
			default:    return comp_t'(int'($urandom_range(4096)) - 2048);
		endcase
	endfunction

	// compares get B steered close to A (or to -A) most of the time
	function automatic qau_req_t random_beat(input int tol);
		comp_t av[4];
		comp_t bv[4];
		int    span;
		int    off;
		int    i;
		bit    flip;
		logic [3:0] cmd;
		if ($urandom_range(99) < 6) begin
			cmd = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
		end else begin
			cmd = 4'($urandom_range(CMD_ORIENT));
		end
		for (i = 0; i < 4; i++) begin
			av[i] = rand_comp();
			bv[i] = rand_comp();
		end
		if ((cmd == CMD_EQUAL || cmd == CMD_ORIENT) && $urandom_range(9) < 7) begin
			span = (tol <= 64) ? tol + 2 : tol;
			flip = (cmd == CMD_ORIENT) && $urandom_range(1);
			for (i = 0; i < 4; i++) begin
				if ($urandom_range(3) == 0) begin
					off = $urandom_range(1) ? tol : -tol;
				end else begin
					off = int'($urandom_range(2 * span)) - span;
				end
				bv[i] = comp_t'((flip ? -int'(av[i]) : int'(av[i])) + off);
			end
		end
		return make_beat(cmd, av[0], av[1], av[2], av[3], bv[0], bv[1], bv[2], bv[3]);
	endfunction

	task automatic send_beat(input qau_req_t req);
		while (!steady && $urandom_range(99) < 31) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data  <= req;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		beats_sent++;
	endtask

	// tolerance may only change with nothing in flight
	task automatic update_tolerance(input logic [EPS_W-1:0] tol);
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		eps_we    <= 1'b1;
		eps_wdata <= tol;
		@(posedge clk);
		eps_we <= 1'b0;
		settings_used++;
	endtask

	initial begin : stimulus
		logic [EPS_W-1:0] tol;
		int               ph;
		int               waited;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		settings_used = 1;

		// directed beats at the reset tolerance of 16
		send_beat(make_beat(CMD_ADD, CMAX, CMIN, 1, 0, 1, -1, -1, 0));
		send_beat(make_beat(CMD_ADD, 100, -200, 300, UNIT, -50, 50, 7, UNIT));
		send_beat(make_beat(CMD_SUB, CMIN, CMAX, 0, 5, 1, -1, CMIN, 5));
		send_beat(make_beat(CMD_NEGATE, CMIN, CMAX, 0, -1, 0, 0, 0, 0));
		send_beat(make_beat(CMD_CONJ, CMIN, 1, -1, CMIN, CMAX, CMAX, CMAX, CMAX));
		send_beat(make_beat(CMD_SCALE, CMIN, CMAX, 1, -1, 0, 0, 0, CMIN));
		// half-LSB ties round toward plus infinity
		send_beat(make_beat(CMD_SCALE, 1, -1, 3, -3, 0, 0, 0, HALF));
		send_beat(make_beat(CMD_PRODUCT, 0, 0, 0, UNIT, 1000, -2000, 3000, UNIT));
		send_beat(make_beat(CMD_PRODUCT, UNIT, 0, 0, 0, 0, UNIT, 0, 0));
		send_beat(make_beat(CMD_PRODUCT, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
		send_beat(make_beat(CMD_PRODUCT, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
		send_beat(make_beat(CMD_ROTATE, 0, 0, 0, UNIT, 1234, -5678, CMAX, 0));
		send_beat(make_beat(CMD_ROTATE, 0, 0, COS45, COS45, UNIT, 0, 0, 0));
		send_beat(make_beat(CMD_ROTATE, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
		send_beat(make_beat(CMD_ROTATE, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX));
		send_beat(make_beat(CMD_DOT, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
		send_beat(make_beat(CMD_DOT, 0, 0, 0, UNIT, 5, 6, 7, UNIT));
		send_beat(make_beat(CMD_EQUAL, 100, 200, -300, CMAX, 116, 184, -300, CMAX - 16));
		send_beat(make_beat(CMD_EQUAL, 100, 200, -300, CMAX, 117, 184, -300, CMAX - 16));
		send_beat(make_beat(CMD_ORIENT, 1000, -2000, 3000, -4000, -1016, 2000, -2990, 4016));
		send_beat(make_beat(CMD_ORIENT, 1000, -2000, 3000, -4000, -1017, 2000, -2990, 4016));
		send_beat(make_beat(CMD_ORIENT, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
		send_beat(make_beat(CMD_UNUSED_LO, CMAX, 1, 2, 3, 4, 5, 6, CMIN));
		send_beat(make_beat(CMD_UNUSED_HI, CMIN, -1, -2, -3, -4, -5, -6, CMAX));

		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0:       tol = '0;
				1:       tol = EPS_MAX;
				2:       tol = EPS_W'($urandom);
				3:       tol = EPS_W'(1);
				default: tol = EPS_W'($urandom_range(64));
			endcase
			update_tolerance(tol);
			steady = (ph == 2);
			repeat (PHASE_BEATS) send_beat(random_beat(int'(tol)));
		end
		steady = 1'b0;

		cmd_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (pending != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);

		$display("Sent %0d command beats under %0d tolerance settings; %0d result beats checked.",
			beats_sent, settings_used, checked);
		$display("Covered all ten commands, undefined codes, clipping and rounding ties.");
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/qau_pkg.sv
rtl/core/qau_direct.sv
rtl/core/quaternion_arithmetic_unit.sv
sim/qau_result_checker.sv
sim/tb.sv
